@@ sv/sql_statement_splitter_unit_assert.svh @@
// ---------------------------------------------------------------------------
// SQL statement splitter assertion macros
// Shared assertion forms, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SQL_STATEMENT_SPLITTER_UNIT_ASSERT_SVH
`define SQL_STATEMENT_SPLITTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sqlsplit_pkg.sv @@
// ---------------------------------------------------------------------------
// SQL statement splitter package
// Result kinds, character codes and the types shared by the splitter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sqlsplit_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        KIND_BYTE        = 3'd0,
        KIND_END         = 3'd1,
        KIND_OPEN_STRING = 3'd2,
        KIND_NO_SEMI     = 3'd3,
        KIND_DONE        = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [15:0] byte_offset;
        logic [15:0] trimmed_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
    } t_result;

    // One request's results: the first always, the second when two is set.
    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

@@ sv/sqlsplit_fifo.sv @@
// ---------------------------------------------------------------------------
// SQL statement splitter queue
// Short register queue of result entries between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module sqlsplit_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire sqlsplit_pkg::t_entry  i_entry,
    input  wire logic                  i_pop,
    output sqlsplit_pkg::t_entry       o_head,
    output sqlsplit_pkg::t_qstat       o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sqlsplit_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head = r_mem[r_rd];
    assign o_status = '{full: (r_count == CW'(DEPTH)), empty: (r_count == '0)};

endmodule

`default_nettype wire

@@ sv/sqlsplit_front.sv @@
// ---------------------------------------------------------------------------
// SQL statement splitter front part
// Classifies each byte, tracks strings, comments and positions, and forms
// the one or two results that a request causes.
// ---------------------------------------------------------------------------
`default_nettype none

module sqlsplit_front #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_text_byte,
    input  wire logic                  i_end_of_input,
    output logic                       o_push,
    output sqlsplit_pkg::t_entry       o_entry
);

    localparam int PW = POSITION_WIDTH;
    localparam int EW = (PW > 16) ? PW : 16;

    typedef struct packed {
        logic          hc;
        logic [PW-1:0] sl;
        logic [PW-1:0] sc;
        logic [PW-1:0] bk;
        logic [PW-1:0] len;
    } t_kst;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] to16(input logic [PW-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        return e[15:0];
    endfunction

    function automatic t_kst keep_upd(input t_kst s, input logic [7:0] b,
                                      input logic [PW-1:0] line,
                                      input logic [PW-1:0] col);
        t_kst r;
        r = s;
        if (!r.hc) begin
            r.sl = line;
            r.sc = col;
            r.hc = 1'b1;
        end
        r.bk = sat_inc(s.bk);
        if (!sqlsplit_pkg::is_ws(b)) begin
            r.len = r.bk;
        end
        return r;
    endfunction

    function automatic sqlsplit_pkg::t_result mk(input sqlsplit_pkg::t_kind kind,
                                                 input logic [7:0] b,
                                                 input logic [PW-1:0] off,
                                                 input logic [PW-1:0] len,
                                                 input logic [PW-1:0] line,
                                                 input logic [PW-1:0] col);
        sqlsplit_pkg::t_result r;
        r.kind = kind;
        r.out_byte = b;
        r.byte_offset = to16(off);
        r.trimmed_length = to16(len);
        r.line_number = to16(line);
        r.column_number = to16(col);
        return r;
    endfunction

    localparam logic [PW-1:0] ONE = PW'(1);

    t_kst          r_k;
    logic          r_str;
    logic          r_com;
    logic          r_dash;
    logic [PW-1:0] r_dl;
    logic [PW-1:0] r_dc;
    logic [PW-1:0] r_cl;
    logic [PW-1:0] r_cc;

    t_kst          n_k;
    logic          n_str;
    logic          n_com;
    logic          n_dash;
    logic [PW-1:0] n_dl;
    logic [PW-1:0] n_dc;
    logic [PW-1:0] n_cl;
    logic [PW-1:0] n_cc;

    sqlsplit_pkg::t_result v_res [2];
    logic [1:0]    v_cnt;
    logic          v_step;
    logic          v_done;
    logic [7:0]    c;

    always_comb begin
        c = i_text_byte;
        n_k = r_k;
        n_str = r_str;
        n_com = r_com;
        n_dash = r_dash;
        n_dl = r_dl;
        n_dc = r_dc;
        n_cl = r_cl;
        n_cc = r_cc;
        v_res[0] = '0;
        v_res[1] = '0;
        v_cnt = 2'd0;
        v_step = 1'b0;
        v_done = 1'b0;
        if (i_end_of_input) begin
            if (r_dash) begin
                v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_BYTE, sqlsplit_pkg::CH_DASH,
                                     n_k.bk, '0, r_dl, r_dc);
                n_k = keep_upd(n_k, sqlsplit_pkg::CH_DASH, r_dl, r_dc);
                v_cnt = v_cnt + 2'd1;
            end
            if (r_str) begin
                v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_OPEN_STRING, 8'h00, '0, '0,
                                     r_cl, r_cc);
            end else if (n_k.hc) begin
                v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_NO_SEMI, 8'h00, '0, '0,
                                     n_k.sl, n_k.sc);
            end else begin
                v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_DONE, 8'h00, '0, '0,
                                     r_cl, r_cc);
            end
            v_cnt = v_cnt + 2'd1;
            n_k = '{hc: 1'b0, sl: ONE, sc: ONE, bk: '0, len: '0};
            n_str = 1'b0;
            n_com = 1'b0;
            n_dash = 1'b0;
            n_dl = ONE;
            n_dc = ONE;
            n_cl = ONE;
            n_cc = ONE;
        end else begin
            v_step = 1'b1;
            if (r_com && (c != sqlsplit_pkg::CH_NL)) begin
                v_done = 1'b1;
            end else begin
                n_com = 1'b0;
                if (r_dash) begin
                    n_dash = 1'b0;
                    if (c == sqlsplit_pkg::CH_DASH) begin
                        n_com = 1'b1;
                        v_done = 1'b1;
                    end else begin
                        v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_BYTE,
                                             sqlsplit_pkg::CH_DASH, n_k.bk, '0,
                                             r_dl, r_dc);
                        n_k = keep_upd(n_k, sqlsplit_pkg::CH_DASH, r_dl, r_dc);
                        v_cnt = v_cnt + 2'd1;
                    end
                end
            end
            if (!v_done) begin
                if (!r_str && (c == sqlsplit_pkg::CH_DASH)) begin
                    n_dash = 1'b1;
                    n_dl = r_cl;
                    n_dc = r_cc;
                end else if (!n_k.hc && sqlsplit_pkg::is_ws(c)) begin
                    n_k = n_k;
                end else if (c == sqlsplit_pkg::CH_QUOTE) begin
                    v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_BYTE, c, n_k.bk, '0,
                                         r_cl, r_cc);
                    n_k = keep_upd(n_k, c, r_cl, r_cc);
                    v_cnt = v_cnt + 2'd1;
                    n_str = !r_str;
                end else if ((c == sqlsplit_pkg::CH_SEMI) && !r_str) begin
                    if (n_k.hc) begin
                        v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_END, 8'h00, '0,
                                             n_k.len, n_k.sl, n_k.sc);
                        v_cnt = v_cnt + 2'd1;
                    end
                    n_k.hc = 1'b0;
                    n_k.bk = '0;
                    n_k.len = '0;
                end else begin
                    v_res[v_cnt[0]] = mk(sqlsplit_pkg::KIND_BYTE, c, n_k.bk, '0,
                                         r_cl, r_cc);
                    n_k = keep_upd(n_k, c, r_cl, r_cc);
                    v_cnt = v_cnt + 2'd1;
                end
            end
            if (v_step) begin
                if (c == sqlsplit_pkg::CH_NL) begin
                    n_cl = sat_inc(r_cl);
                    n_cc = ONE;
                end else begin
                    n_cc = sat_inc(r_cc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '{hc: 1'b0, sl: ONE, sc: ONE, bk: '0, len: '0};
            r_str <= 1'b0;
            r_com <= 1'b0;
            r_dash <= 1'b0;
            r_dl <= ONE;
            r_dc <= ONE;
            r_cl <= ONE;
            r_cc <= ONE;
        end else if (i_accept) begin
            r_k <= n_k;
            r_str <= n_str;
            r_com <= n_com;
            r_dash <= n_dash;
            r_dl <= n_dl;
            r_dc <= n_dc;
            r_cl <= n_cl;
            r_cc <= n_cc;
        end
    end

    assign o_push = i_accept && (v_cnt != 2'd0);
    assign o_entry = '{r0: v_res[0], r1: v_res[1], two: v_cnt[1]};

endmodule

`default_nettype wire

@@ sv/sqlsplit_back.sv @@
// ---------------------------------------------------------------------------
// SQL statement splitter back part
// Takes queued entries apart into single results and drives the output
// register of the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module sqlsplit_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sqlsplit_pkg::t_entry  i_head,
    input  wire sqlsplit_pkg::t_qstat  i_qstat,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [71:0]                o_m_tdata,
    output logic [2:0]                 o_m_tuser,
    output logic                       o_m_tlast
);

    logic                  r_valid;
    logic                  r_half;
    sqlsplit_pkg::t_result r_res;
    logic                  r_last;
    logic                  w_load;
    logic                  w_take;

    assign w_load = !r_valid || i_m_tready;
    assign w_take = w_load && !i_qstat.empty;
    assign o_pop = w_take && (r_half || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_qstat.empty;
            if (w_take) begin
                r_half <= !r_half && i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= r_half ? i_head.r1 : i_head.r0;
            r_last <= r_half || !i_head.two;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata = {r_res.column_number, r_res.line_number, r_res.trimmed_length,
                        r_res.byte_offset, r_res.out_byte};
    assign o_m_tuser = r_res.kind;
    assign o_m_tlast = r_last;

endmodule

`default_nettype wire

@@ sv/sql_statement_splitter_unit.sv @@
// Path: an accepted request's entry is written into the queue, and its results are loaded
// from there into the back part's output register; a second result follows the first.
// Throughput: one text byte per cycle while the four-entry queue between the front and
// back parts has room; the input is held off only while that queue is full.
// Reset: synchronous, active low; clears all parser state, the queue and the output valid.
// ---------------------------------------------------------------------------
// SQL statement splitter
// Splits a byte stream of SQL text into statements, dropping comments and
// leading whitespace, and reports statement ends and end-of-text status.
// ---------------------------------------------------------------------------
`default_nettype none

module sql_statement_splitter_unit #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // text_byte [7:0]
    input  wire logic        i_s_tlast,   // end_of_input
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // out_byte [7:0], byte_offset [23:8],
                                          // trimmed_length [39:24],
                                          // line_number [55:40],
                                          // column_number [71:56]
    output logic [2:0]       o_m_tuser,   // kind [2:0]
    output logic             o_m_tlast    // last
);

    logic                 w_accept;
    logic                 w_push;
    logic                 w_pop;
    sqlsplit_pkg::t_entry w_entry;
    sqlsplit_pkg::t_entry w_head;
    sqlsplit_pkg::t_qstat w_qstat;
    logic                 w_res_byte;
    logic                 w_res_status;

    assign o_s_tready = !w_qstat.full;
    assign w_accept = i_s_tvalid && o_s_tready;

    sqlsplit_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_text_byte    (i_s_tdata),
        .i_end_of_input (i_s_tlast),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    sqlsplit_fifo #(
        .DEPTH(sqlsplit_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    sqlsplit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign w_res_byte = (o_m_tuser == sqlsplit_pkg::KIND_BYTE);
    assign w_res_status = (o_m_tuser == sqlsplit_pkg::KIND_OPEN_STRING) ||
                          (o_m_tuser == sqlsplit_pkg::KIND_NO_SEMI) ||
                          (o_m_tuser == sqlsplit_pkg::KIND_DONE);

`include "sql_statement_splitter_unit_assert.svh"

    `SSU_ASSERT_NOW(a_pop_not_empty, w_pop, !w_qstat.empty, "pop from an empty queue")
    `SSU_ASSERT_NEXT(a_push_fills, w_push, !w_qstat.empty, "queue empty after a push")
    `SSU_ASSERT_NOW(a_first_is_byte, o_m_tvalid && !o_m_tlast, w_res_byte, "early non-byte")
    `SSU_ASSERT_NOW(a_status_last, o_m_tvalid && w_res_status, o_m_tlast, "status not final")

endmodule

`default_nettype wire

@@ test/tb_sql_statement_splitter_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL statement splitter testbench
// Feeds directed and random SQL text requests, with end-of-text marks, into
// the splitter under random back-pressure and idle gaps. A scoreboard
// predicts every result from its own copy of the parser state and checks
// each result in order, field by field.
// ---------------------------------------------------------------------------

module tb_sql_statement_splitter_unit;

    localparam int          CYCLE_LIMIT  = 4000000;
    localparam int          RANDOM_ITEMS = 1350;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 8;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [15:0] POS_TOP      = 16'hFFFF;

    class statement_scoreboard;
        logic        quoted;
        logic        in_comment;
        logic        open_stmt;
        logic        dash_held;
        logic [15:0] dash_line;
        logic [15:0] dash_col;
        logic [15:0] cur_line;
        logic [15:0] cur_col;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic [15:0] kept;
        logic [15:0] trim_len;
        sqlsplit_pkg::t_result batch[2];
        int          batch_n;
        sqlsplit_pkg::t_result pending_results[$];
        logic        pending_last[$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
            clear();
        endfunction

        function void clear();
            quoted      = 1'b0;
            in_comment  = 1'b0;
            open_stmt   = 1'b0;
            dash_held   = 1'b0;
            dash_line   = 16'd1;
            dash_col    = 16'd1;
            cur_line    = 16'd1;
            cur_col     = 16'd1;
            start_line  = 16'd1;
            start_col   = 16'd1;
            kept        = 16'd0;
            trim_len    = 16'd0;
        endfunction

        function logic [15:0] bump(input logic [15:0] v);
            return (v == POS_TOP) ? v : v + 16'd1;
        endfunction

        function logic blank(input logic [7:0] c);
            return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void advance(input logic [7:0] c);
            if (c == sqlsplit_pkg::CH_NL) begin
                cur_line = bump(cur_line);
                cur_col  = 16'd1;
            end else begin
                cur_col = bump(cur_col);
            end
        endfunction

        function void add(input sqlsplit_pkg::t_kind k, input logic [7:0] b,
                          input logic [15:0] off, input logic [15:0] len,
                          input logic [15:0] ln, input logic [15:0] col);
            sqlsplit_pkg::t_result r;
            r.kind           = k;
            r.out_byte       = b;
            r.byte_offset    = off;
            r.trimmed_length = len;
            r.line_number    = ln;
            r.column_number  = col;
            batch[batch_n]   = r;
            batch_n++;
        endfunction

        function void keep(input logic [7:0] c, input logic [15:0] ln, input logic [15:0] col);
            if (!open_stmt) begin
                start_line  = ln;
                start_col   = col;
                open_stmt   = 1'b1;
            end
            add(sqlsplit_pkg::KIND_BYTE, c, kept, 16'd0, ln, col);
            kept = bump(kept);
            if (!blank(c))
                trim_len = kept;
        endfunction

        function void note_request(input logic [7:0] c, input logic eoi);
            logic skip;
            batch_n = 0;
            skip    = 1'b0;
            if (eoi) begin
                if (dash_held) begin
                    dash_held = 1'b0;
                    keep(sqlsplit_pkg::CH_DASH, dash_line, dash_col);
                end
                if (quoted)
                    add(sqlsplit_pkg::KIND_OPEN_STRING, 8'd0, 16'd0, 16'd0,
                        cur_line, cur_col);
                else if (open_stmt)
                    add(sqlsplit_pkg::KIND_NO_SEMI, 8'd0, 16'd0, 16'd0,
                        start_line, start_col);
                else
                    add(sqlsplit_pkg::KIND_DONE, 8'd0, 16'd0, 16'd0, cur_line, cur_col);
                clear();
            end else begin
                if (in_comment) begin
                    if (c != sqlsplit_pkg::CH_NL) begin
                        advance(c);
                        skip = 1'b1;
                    end else begin
                        in_comment = 1'b0;
                    end
                end
                if (!skip && dash_held) begin
                    dash_held = 1'b0;
                    if (c == sqlsplit_pkg::CH_DASH) begin
                        in_comment = 1'b1;
                        advance(c);
                        skip = 1'b1;
                    end else begin
                        keep(sqlsplit_pkg::CH_DASH, dash_line, dash_col);
                    end
                end
                if (!skip) begin
                    if (!quoted && c == sqlsplit_pkg::CH_DASH) begin
                        dash_held = 1'b1;
                        dash_line = cur_line;
                        dash_col  = cur_col;
                    end else if (!open_stmt && blank(c)) begin
                    end else if (c == sqlsplit_pkg::CH_QUOTE) begin
                        keep(c, cur_line, cur_col);
                        quoted = !quoted;
                    end else if (c == sqlsplit_pkg::CH_SEMI && !quoted) begin
                        if (open_stmt)
                            add(sqlsplit_pkg::KIND_END, 8'd0, 16'd0, trim_len,
                                start_line, start_col);
                        open_stmt   = 1'b0;
                        kept        = 16'd0;
                        trim_len    = 16'd0;
                    end else begin
                        keep(c, cur_line, cur_col);
                    end
                    advance(c);
                end
            end
            for (int i = 0; i < batch_n; i++) begin
                pending_results.push_back(batch[i]);
                pending_last.push_back(i == batch_n - 1);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR at %0t: result %0d: %s", $realtime, checked, msg);
        endtask

        task check_result(input logic [2:0] kind, input logic [71:0] data, input logic last);
            sqlsplit_pkg::t_result want;
            logic    want_last;
            if (pending_results.size() == 0) begin
                report("result arrived with nothing expected");
            end else begin
                want      = pending_results.pop_front();
                want_last = pending_last.pop_front();
                if (kind !== want.kind)
                    report($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (data[7:0] !== want.out_byte)
                    report($sformatf("out_byte %0h, expected %0h", data[7:0], want.out_byte));
                if (data[23:8] !== want.byte_offset)
                    report($sformatf("byte_offset %0d, expected %0d", data[23:8],
                                     want.byte_offset));
                if (data[39:24] !== want.trimmed_length)
                    report($sformatf("trimmed_length %0d, expected %0d", data[39:24],
                                     want.trimmed_length));
                if (data[55:40] !== want.line_number)
                    report($sformatf("line_number %0d, expected %0d", data[55:40],
                                     want.line_number));
                if (data[71:56] !== want.column_number)
                    report($sformatf("column_number %0d, expected %0d", data[71:56],
                                     want.column_number));
                if (last !== want_last)
                    report($sformatf("last %0b, expected %0b", last, want_last));
            end
            checked++;
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    statement_scoreboard sb = new();
    logic [8:0]          script[$];
    logic                no_idle      = 1'b0;
    logic                hold_off_req = 1'b0;
    int unsigned         cycle_count  = 0;

    sql_statement_splitter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata, o_m_tlast);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] blank_char();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : 8'h09 + pick[7:0];
    endfunction

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        script.push_back({1'b0, b});
    endfunction

    function automatic void add_end();
        script.push_back({1'b1, any_char()});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void compose_statement();
        repeat ($urandom_range(0, 3)) add_byte(blank_char());
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 6)) add_byte(word_char());
                end
                3: begin
                    add_byte(CH_SPACE);
                end
                4: begin
                    add_byte(sqlsplit_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 4)) add_byte(any_char());
                    if ($urandom_range(0, 2) == 0) begin
                        add_byte(sqlsplit_pkg::CH_QUOTE);
                        add_byte(sqlsplit_pkg::CH_QUOTE);
                    end
                    add_byte(sqlsplit_pkg::CH_QUOTE);
                end
                5: begin
                    add_byte(sqlsplit_pkg::CH_DASH);
                    add_byte(sqlsplit_pkg::CH_DASH);
                    repeat ($urandom_range(0, 5)) add_byte(any_char());
                    add_byte(sqlsplit_pkg::CH_NL);
                end
                6: begin
                    add_byte(sqlsplit_pkg::CH_DASH);
                    add_byte(word_char());
                end
                7: begin
                    add_byte(sqlsplit_pkg::CH_NL);
                end
                8: begin
                    add_byte(any_char());
                end
                default: begin
                    add_byte(blank_char());
                end
            endcase
        end
        repeat ($urandom_range(0, 2)) add_byte(blank_char());
        if ($urandom_range(0, 9) != 0)
            add_byte(sqlsplit_pkg::CH_SEMI);
    endfunction

    task automatic offer(input logic [8:0] item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= item[7:0];
        i_s_tlast  <= item[8];
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(item[7:0], item[8]);
    endtask

    task automatic play();
        while (script.size() != 0)
            offer(script.pop_front());
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int held;
        int span;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else begin
                span = pick_gap();
                if (span == 0) begin
                    i_m_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end else begin
                    i_m_tready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("sql_statement_splitter_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int round;
        int roll;
        sent  = 0;
        round = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading blanks, extreme bytes, a held dash before a letter, a comment,
        // a doubled quote inside a string that holds a semicolon, trimming and an empty statement.
        add_byte(8'h09);
        add_byte(8'h0D);
        add_byte(CH_SPACE);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("-x -");
        add_text("-c");
        add_byte(sqlsplit_pkg::CH_NL);
        add_text("'a'';'");
        add_byte(8'h0B);
        add_byte(8'h0C);
        add_byte(sqlsplit_pkg::CH_SEMI);
        add_byte(sqlsplit_pkg::CH_SEMI);
        add_byte(sqlsplit_pkg::CH_DASH);
        add_end();
        add_byte(sqlsplit_pkg::CH_QUOTE);
        add_end();
        add_end();
        play();
        drain();

        while (sent < RANDOM_ITEMS) begin
            round++;
            no_idle = (round % 12) >= 9;
            if (round == 20) begin
                hold_off_req = 1'b1;
                no_idle      = 1'b1;
                repeat (40) add_byte(word_char());
                add_byte(sqlsplit_pkg::CH_SEMI);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    compose_statement();
                end else if (roll < 90) begin
                    repeat ($urandom_range(1, 8)) add_byte(any_char());
                end else if (roll < 95) begin
                    add_end();
                end else begin
                    add_byte(word_char());
                    add_byte(sqlsplit_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 3)) add_byte(any_char());
                    add_end();
                end
            end
            sent += script.size();
            play();
            if (round % 25 == 0)
                drain();
        end
        no_idle = 1'b0;
        add_end();
        play();
        drain();

        if (sb.errors == 0)
            $display("sql_statement_splitter_unit: match");
        else
            $display("sql_statement_splitter_unit: mismatch");
        $finish;
    end

endmodule
